[src/mkrc_pkg.sv]
// shared types, constants and helper functions of the multi-key record comparator
package mkrc_pkg;

    localparam int MKRC_MAX_KEYS   = 4;
    localparam int SLOT_W          = 2;
    localparam int CHUNK_W         = 64;
    localparam int BYTES_W         = 4;
    localparam int CHUNK_BYTES     = 8;
    localparam int KEY_COUNT_W     = 3;
    localparam int KEY_TYPES_W     = 12;
    localparam int KEY_DESC_W      = 4;
    localparam int TYPE_W          = 3;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 12;
    localparam int S_TDATA_W       = 136;
    localparam int S_TUSER_W       = 3;
    localparam int M_TDATA_W       = 8;

    typedef logic signed [1:0] verdict_t;

    localparam verdict_t VERDICT_LT = -2'sd1;
    localparam verdict_t VERDICT_EQ = 2'sd0;
    localparam verdict_t VERDICT_GT = 2'sd1;

    typedef enum logic [TYPE_W-1:0] {
        KT_INT32   = 3'd0,
        KT_UINT32  = 3'd1,
        KT_INT64   = 3'd2,
        KT_UINT64  = 3'd3,
        KT_FLOAT32 = 3'd4,
        KT_STRING  = 3'd5,
        KT_IGNORE  = 3'd6
    } key_type_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KEY_COUNT = 2'd0,
        CFG_KEY_TYPES = 2'd1,
        CFG_KEY_DESC  = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic [KEY_COUNT_W-1:0] key_count;
        logic [KEY_TYPES_W-1:0] key_types;
        logic [KEY_DESC_W-1:0]  key_descending;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  key_slot;
        logic [CHUNK_W-1:0] chunk_a;
        logic [CHUNK_W-1:0] chunk_b;
        logic [BYTES_W-1:0] chunk_bytes;
        logic               key_last;
        logic               record_last;
    } item_t;

    typedef struct packed {
        verdict_t verdict;   // direction applied, zero when the key gives no order
        logic     str_end;   // shared nul seen in this chunk
    } cmp_t;

    function automatic verdict_t order_u64(input logic [CHUNK_W-1:0] a,
                                           input logic [CHUNK_W-1:0] b);
        verdict_t r;
        if (a == b) begin
            r = VERDICT_EQ;
        end else if (a > b) begin
            r = VERDICT_GT;
        end else begin
            r = VERDICT_LT;
        end
        return r;
    endfunction

    function automatic verdict_t apply_dir(input verdict_t r, input logic desc);
        verdict_t v;
        v = desc ? verdict_t'(-r) : r;
        return v;
    endfunction

    function automatic logic [31:0] float_key(input logic [31:0] x);
        logic [31:0] k;
        k = x[31] ? ~x : (x | 32'h8000_0000);
        return k;
    endfunction

endpackage

[src/mkrc_cfg_regs.sv]
// configuration register file: key count, per-slot types and directions
module mkrc_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mkrc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mkrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output mkrc_pkg::cfg_t                    cfg
);

    mkrc_pkg::cfg_t cfg_reg;
    mkrc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (mkrc_pkg::cfg_addr_t'(cfg_addr))
                mkrc_pkg::CFG_KEY_COUNT: begin
                    cfg_next.key_count = cfg_wdata[mkrc_pkg::KEY_COUNT_W-1:0];
                end
                mkrc_pkg::CFG_KEY_TYPES: begin
                    cfg_next.key_types = cfg_wdata[mkrc_pkg::KEY_TYPES_W-1:0];
                end
                mkrc_pkg::CFG_KEY_DESC: begin
                    cfg_next.key_descending = cfg_wdata[mkrc_pkg::KEY_DESC_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_count      <= mkrc_pkg::KEY_COUNT_W'(1);
            cfg_reg.key_types      <= '0;
            cfg_reg.key_descending <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/mkrc_in_stage.sv]
// input register stage: captures one key chunk word per cycle while it is empty or its held word advances
module mkrc_in_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mkrc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [mkrc_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             s_tlast,
    input  logic                             advance,
    output logic                             item_valid,
    output mkrc_pkg::item_t                  item
);

    logic            valid_reg;
    logic            valid_next;
    mkrc_pkg::item_t item_reg;
    mkrc_pkg::item_t item_next;
    logic            take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        item_next = item_reg;
        if (take) begin
            item_next.key_slot    = s_tuser[1:0];
            item_next.key_last    = s_tuser[2];
            item_next.chunk_a     = s_tdata[63:0];
            item_next.chunk_b     = s_tdata[127:64];
            item_next.chunk_bytes = s_tdata[131:128];
            item_next.record_last = s_tlast;
        end
        valid_next = take || (valid_reg && !advance);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/mkrc_key_cmp.sv]
// combinational compare of one key chunk of both records
module mkrc_key_cmp #(
    parameter int MaxKeys = mkrc_pkg::MKRC_MAX_KEYS
) (
    input  mkrc_pkg::item_t item,
    input  mkrc_pkg::cfg_t  cfg,
    input  logic            string_ended,
    output mkrc_pkg::cmp_t  cmp
);

    logic                                slot_active;
    logic [mkrc_pkg::KEY_TYPES_W-1:0]    types_sh;
    logic [mkrc_pkg::TYPE_W-1:0]         type_code;
    logic                                desc;
    logic [31:0]                         fa;
    logic [31:0]                         fb;
    logic                                any_nan;
    logic                                both_zero;
    logic [mkrc_pkg::BYTES_W-1:0]        byte_cnt;
    logic                                str_stop;
    logic                                str_nul;
    logic [7:0]                          ba;
    logic [7:0]                          bb;
    mkrc_pkg::verdict_t                  str_r;
    mkrc_pkg::verdict_t                  r;

    assign slot_active = (int'(item.key_slot) < int'(cfg.key_count)) &&
                         (int'(item.key_slot) < MaxKeys);
    assign types_sh  = cfg.key_types >> (4'(item.key_slot) * 4'd3);
    assign type_code = types_sh[mkrc_pkg::TYPE_W-1:0];
    assign desc      = cfg.key_descending[item.key_slot];

    assign fa        = item.chunk_a[31:0];
    assign fb        = item.chunk_b[31:0];
    assign any_nan   = (fa[30:0] > 31'h7F80_0000) || (fb[30:0] > 31'h7F80_0000);
    assign both_zero = (fa[30:0] == '0) && (fb[30:0] == '0);

    // byte-wise string compare over the valid bytes, byte 0 first, stops at first difference or shared nul
    always_comb begin
        byte_cnt = (item.chunk_bytes > mkrc_pkg::BYTES_W'(mkrc_pkg::CHUNK_BYTES)) ?
                   mkrc_pkg::BYTES_W'(mkrc_pkg::CHUNK_BYTES) : item.chunk_bytes;
        str_stop = 1'b0;
        str_nul  = 1'b0;
        str_r    = mkrc_pkg::VERDICT_EQ;
        ba       = '0;
        bb       = '0;
        for (int i = 0; i < mkrc_pkg::CHUNK_BYTES; i++) begin
            ba = item.chunk_a[8*i +: 8];
            bb = item.chunk_b[8*i +: 8];
            if (!str_stop && (mkrc_pkg::BYTES_W'(i) < byte_cnt)) begin
                if (ba != bb) begin
                    str_r    = (ba > bb) ? mkrc_pkg::VERDICT_GT : mkrc_pkg::VERDICT_LT;
                    str_stop = 1'b1;
                end else if (ba == 8'd0) begin
                    str_nul  = 1'b1;
                    str_stop = 1'b1;
                end
            end
        end
    end

    always_comb begin
        r           = mkrc_pkg::VERDICT_EQ;
        cmp.str_end = 1'b0;
        if (slot_active) begin
            case (type_code)
                mkrc_pkg::KT_INT32: begin
                    r = mkrc_pkg::apply_dir(
                        mkrc_pkg::order_u64({32'd0, fa ^ 32'h8000_0000},
                                            {32'd0, fb ^ 32'h8000_0000}), desc);
                end
                mkrc_pkg::KT_UINT32: begin
                    r = mkrc_pkg::apply_dir(
                        mkrc_pkg::order_u64({32'd0, fa}, {32'd0, fb}), desc);
                end
                mkrc_pkg::KT_INT64: begin
                    r = mkrc_pkg::apply_dir(
                        mkrc_pkg::order_u64(item.chunk_a ^ 64'h8000_0000_0000_0000,
                                            item.chunk_b ^ 64'h8000_0000_0000_0000), desc);
                end
                mkrc_pkg::KT_UINT64: begin
                    r = mkrc_pkg::apply_dir(
                        mkrc_pkg::order_u64(item.chunk_a, item.chunk_b), desc);
                end
                mkrc_pkg::KT_FLOAT32: begin
                    if (any_nan) begin
                        r = desc ? mkrc_pkg::VERDICT_GT : mkrc_pkg::VERDICT_LT;
                    end else if (both_zero) begin
                        r = mkrc_pkg::VERDICT_EQ;
                    end else begin
                        r = mkrc_pkg::apply_dir(
                            mkrc_pkg::order_u64({32'd0, mkrc_pkg::float_key(fa)},
                                                {32'd0, mkrc_pkg::float_key(fb)}), desc);
                    end
                end
                mkrc_pkg::KT_STRING: begin
                    if (!string_ended) begin
                        r           = mkrc_pkg::apply_dir(str_r, desc);
                        cmp.str_end = str_nul;
                    end
                end
                default: begin
                    r = mkrc_pkg::VERDICT_EQ;
                end
            endcase
        end
        cmp.verdict = r;
    end

endmodule

[src/mkrc_verdict.sv]
// record-pair state and the registered verdict output
module mkrc_verdict (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             item_valid,
    input  mkrc_pkg::item_t                  item,
    input  mkrc_pkg::cmp_t                   cmp,
    output logic                             string_ended,
    output logic                             advance,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mkrc_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic               decided_reg;
    logic               decided_next;
    mkrc_pkg::verdict_t held_reg;
    mkrc_pkg::verdict_t held_next;
    logic               str_end_reg;
    logic               str_end_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    mkrc_pkg::verdict_t out_verdict_reg;
    mkrc_pkg::verdict_t out_verdict_next;
    logic               hit;
    logic               dec_mid;
    mkrc_pkg::verdict_t held_mid;
    logic               str_mid;

    // a record-closing word waits only while an unread verdict blocks the output
    assign advance = item_valid && (!item.record_last || !out_valid_reg || m_tready);

    assign hit      = !decided_reg && (cmp.verdict != mkrc_pkg::VERDICT_EQ);
    assign dec_mid  = decided_reg || hit;
    assign held_mid = decided_reg ? held_reg : cmp.verdict;
    assign str_mid  = (str_end_reg || (!decided_reg && cmp.str_end)) && !item.key_last;

    always_comb begin
        decided_next     = decided_reg;
        held_next        = held_reg;
        str_end_next     = str_end_reg;
        out_verdict_next = out_verdict_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        if (advance) begin
            decided_next = dec_mid;
            held_next    = held_mid;
            str_end_next = str_mid;
            if (item.record_last) begin
                out_verdict_next = dec_mid ? held_mid : mkrc_pkg::VERDICT_EQ;
                out_valid_next   = 1'b1;
                decided_next     = 1'b0;
                held_next        = mkrc_pkg::VERDICT_EQ;
                str_end_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decided_reg   <= 1'b0;
            held_reg      <= mkrc_pkg::VERDICT_EQ;
            str_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            decided_reg   <= decided_next;
            held_reg      <= held_next;
            str_end_reg   <= str_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_verdict_reg <= out_verdict_next;
    end

    assign string_ended = str_end_reg;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {6'd0, out_verdict_reg};

endmodule

[src/multi_key_record_compare.sv]
// top level of the multi-key record comparator
//
// usage: the sort engine streams the key chunks of two records on the s_ channel,
// one word per key chunk, slot in tuser[1:0], end of key in tuser[2], and tlast on
// the final word of the record pair. the first chunk that differs fixes the order;
// later words of that pair are still taken but change nothing. one verdict word
// per record pair leaves on the m_ channel: -1 first record before, 0 equal,
// 1 first record after (two-bit signed in tdata[1:0]).
// configuration: cfg_we/cfg_addr/cfg_wdata write key count, key types and
// descending flags; write only while no record pair is in flight.
// path: a word is captured in the input register and its verdict is written into
// the output register, so tvalid rises once the tlast word has passed through both.
// throughput: one word per cycle while no unread verdict holds back a tlast word,
// bounded by the single compare path between the input and output registers.
// stall: while a verdict waits unread, non-final words keep flowing; a tlast word
// is held in the input register until the output register frees up.
// reset: synchronous, active low; registers return to key count 1, all slots
// int32 ascending, and any partial record pair is dropped.
module multi_key_record_compare #(
    parameter int MaxKeys = mkrc_pkg::MKRC_MAX_KEYS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [mkrc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mkrc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // key chunk stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // chunk_a [63:0], chunk_b [127:64], chunk_bytes [131:128], zero pad [135:132]
    input  logic [mkrc_pkg::S_TDATA_W-1:0]   s_tdata,
    // key_slot [1:0], key_last [2]
    input  logic [mkrc_pkg::S_TUSER_W-1:0]   s_tuser,
    // record_last
    input  logic                             s_tlast,
    // verdict stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // verdict [1:0] signed, zero pad [7:2]
    output logic [mkrc_pkg::M_TDATA_W-1:0]   m_tdata
);

    mkrc_pkg::cfg_t  cfg;
    mkrc_pkg::item_t item;
    mkrc_pkg::cmp_t  cmp;
    logic            item_valid;
    logic            advance;
    logic            string_ended;

    // register file, to be written only between record pairs; the block does not enforce this
    mkrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register
    mkrc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // per-chunk compare, pure logic
    mkrc_key_cmp #(
        .MaxKeys (MaxKeys)
    ) u_cmp (
        .item         (item),
        .cfg          (cfg),
        .string_ended (string_ended),
        .cmp          (cmp)
    );

    // decided / held verdict / string end state and the output register
    mkrc_verdict u_verdict (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item         (item),
        .cmp          (cmp),
        .string_ended (string_ended),
        .advance      (advance),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

[src/mkrc_checker.sv]
// port-level checks of the multi-key record comparator, bound to the top level
module mkrc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mkrc_pkg::M_TDATA_W-1:0]   m_tdata
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("verdict valid after reset");

    // a verdict is one of -1, 0, 1 with zero padding
    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0) && (m_tdata[1:0] != 2'b10))
        else $error("illegal verdict code");

    // a fresh verdict follows a record-closing word taken through the input register
    a_verdict_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("verdict without closing word");

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict dropped or changed under stall");

endmodule

bind multi_key_record_compare mkrc_checker u_mkrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
